@@ src/keypad_scan_debounce_assert.svh @@
// Assertion macros shared by the keypad scanner modules.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_ASSERT_SVH

// Same-cycle implication.
`define KPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpd_pkg
// Types, constants and the keymap shared by the keypad scanner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

    localparam int HISTORY_BITS_DEF = 8;
    localparam int NUM_ROWS         = 4;
    localparam int NUM_COLS         = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] rows;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] idx;
    } slot_t;

    // ASCII code of a key by key number
    function automatic logic [6:0] key_char_of(input logic [3:0] idx);
        logic [6:0] ch;
        unique case (idx)
            4'd0:    ch = 7'h44; // D
            4'd1:    ch = 7'h43; // C
            4'd2:    ch = 7'h42; // B
            4'd3:    ch = 7'h41; // A
            4'd4:    ch = 7'h23; // #
            4'd5:    ch = 7'h39; // 9
            4'd6:    ch = 7'h36; // 6
            4'd7:    ch = 7'h33; // 3
            4'd8:    ch = 7'h30; // 0
            4'd9:    ch = 7'h38; // 8
            4'd10:   ch = 7'h35; // 5
            4'd11:   ch = 7'h32; // 2
            4'd12:   ch = 7'h2A; // *
            4'd13:   ch = 7'h37; // 7
            4'd14:   ch = 7'h34; // 4
            4'd15:   ch = 7'h31; // 1
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

@@ src/kpd_front.sv @@
// ----------------------------------------------------------------------------
// kpd_front
// Input side: accepts beats, decodes the command and holds them in a
// short queue for the execution side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_scan_debounce_assert.svh"

module kpd_front
    import kpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire logic [3:0] row_bits,
    output logic            q_valid,
    input  wire logic       q_ready,
    output item_t           q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    item_t            item_in;
    logic             push;
    logic             pop;

    always_comb
    begin
        item_in.rows = row_bits;
        unique case (cmd)
            CMD_POP:  item_in.op = OP_POP;
            CMD_SCAN: item_in.op = OP_SCAN;
            default:  item_in.op = OP_SCAN;
        endcase
    end

    assign in_ready = (count_reg != FULL_CNT);
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    `KPD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT, "queue count over depth")
    `KPD_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

`default_nettype wire

@@ src/kpd_back.sv @@
// ----------------------------------------------------------------------------
// kpd_back
// Execution side: debounce histories, key ring, column counter and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keypad_scan_debounce_assert.svh"

module kpd_back
    import kpd_pkg::*;
#(
    parameter int HISTORY_BITS = HISTORY_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire item_t      q_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      column_drive,
    output logic            key_valid,
    output logic [6:0]      key_char,
    output logic [3:0]      key_index
);

    localparam logic [HISTORY_BITS-1:0] PRESS_PATTERN = HISTORY_BITS'(1);

    // hist_reg[0] always belongs to the column being driven; rotate on each tick
    logic [HISTORY_BITS-1:0] hist_reg  [NUM_COLS][NUM_ROWS];
    logic [HISTORY_BITS-1:0] hist_next [NUM_COLS][NUM_ROWS];
    slot_t      slot_reg [2];
    slot_t      slot_next [2];
    logic       ws_reg, ws_next;
    logic       rs_reg, rs_next;
    logic [1:0] col_reg, col_next;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] col_out_reg, col_out_next;
    logic       kv_reg, kv_next;
    logic [6:0] kc_reg, kc_next;
    logic [3:0] ki_reg, ki_next;

    logic       fire;
    slot_t      sel_slot;

    assign q_ready  = !out_valid_reg || out_ready;
    assign fire     = q_valid && q_ready;
    assign sel_slot = slot_reg[rs_reg];

    always_comb
    begin
        logic [HISTORY_BITS-1:0] h_new;
        logic                    ws;

        hist_next      = hist_reg;
        slot_next      = slot_reg;
        ws_next        = ws_reg;
        rs_next        = rs_reg;
        col_next       = col_reg;
        col_out_next   = col_out_reg;
        kv_next        = kv_reg;
        kc_next        = kc_reg;
        ki_next        = ki_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        ws             = ws_reg;
        h_new          = '0;

        if (fire)
        begin
            out_valid_next = 1'b1;
            kv_next        = 1'b0;
            kc_next        = '0;
            ki_next        = '0;
            unique case (q_item.op)
                OP_SCAN:
                begin
                    for (int c = 0; c < NUM_COLS - 1; c++)
                    begin
                        hist_next[c] = hist_reg[c + 1];
                    end
                    // push presses in row order; the ring overwrites
                    for (int r = 0; r < NUM_ROWS; r++)
                    begin
                        h_new = {hist_reg[0][r][HISTORY_BITS-2:0], q_item.rows[r]};
                        hist_next[NUM_COLS-1][r] = h_new;
                        if (h_new == PRESS_PATTERN)
                        begin
                            slot_next[ws] = '{valid: 1'b1, idx: {col_reg, 2'(r)}};
                            ws = ~ws;
                        end
                    end
                    ws_next      = ws;
                    col_next     = col_reg + 2'd1;
                    col_out_next = col_reg + 2'd1;
                end
                OP_POP:
                begin
                    col_out_next = col_reg;
                    if (sel_slot.valid)
                    begin
                        kv_next          = 1'b1;
                        ki_next          = sel_slot.idx;
                        kc_next          = key_char_of(sel_slot.idx);
                        slot_next[rs_reg] = '0;
                        rs_next          = ~rs_reg;
                    end
                end
                default:
                begin
                    col_out_next = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    hist_reg[c][r] <= '0;
                end
            end
            slot_reg[0]   <= '0;
            slot_reg[1]   <= '0;
            ws_reg        <= 1'b0;
            rs_reg        <= 1'b0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hist_reg      <= hist_next;
            slot_reg      <= slot_next;
            ws_reg        <= ws_next;
            rs_reg        <= rs_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_out_reg <= col_out_next;
        kv_reg      <= kv_next;
        kc_reg      <= kc_next;
        ki_reg      <= ki_next;
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = col_out_reg;
    assign key_valid    = kv_reg;
    assign key_char     = kc_reg;
    assign key_index    = ki_reg;

    `KPD_ASSERT_NEXT(a_scan_advance, fire && q_item.op == OP_SCAN, col_reg == $past(col_reg) + 2'd1, "column did not advance")
    `KPD_ASSERT_NEXT(a_pop_empty_hold, fire && q_item.op == OP_POP && !sel_slot.valid, rs_reg == $past(rs_reg) && !key_valid, "empty pop moved ring")
    `KPD_ASSERT_NOW(a_no_key_zero, out_valid && !key_valid, key_char == 7'd0 && key_index == 4'd0, "stale key on empty result")

endmodule

`default_nettype wire

@@ src/keypad_scan_debounce.sv @@
// A beat waits in the input queue, its result in the output register.
// Throughput: one beat per cycle when not stalled; the two-entry input
// queue and the output register let each side stall on its own.
// Reset: asynchronous; clears histories, key ring, column and queue at once.
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// 4x4 key matrix scanner with per-key debounce history and a two-slot key ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_scan_debounce
    import kpd_pkg::*;
#(
    parameter int HISTORY_BITS = HISTORY_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire logic [3:0] row_bits,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      column_drive,
    output logic            key_valid,
    output logic [6:0]      key_char,
    output logic [3:0]      key_index
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    kpd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .row_bits (row_bits),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    kpd_back #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .key_valid    (key_valid),
        .key_char     (key_char),
        .key_index    (key_index)
    );

endmodule

`default_nettype wire

@@ dv/keypad_scan_debounce_tb.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_debounce_tb
// Drives scan ticks and key pops into the keypad scanner with random gaps on
// both channels. Expected column, key flag, character and key number are
// computed from an independent model of the debounce histories and the key
// ring, then compared beat by beat with the scanner output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keypad_scan_debounce_tb;

    import kpd_pkg::*;

    localparam int HIST_W         = HISTORY_BITS_DEF;
    // key number 0 sits in the top byte
    localparam logic [127:0] KEYMAP = "DCBA#9630852*741";
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int CHUNK_ITEMS    = 50;

    typedef struct packed {
        logic [1:0] column;
        logic       valid;
        logic [6:0] ch;
        logic [3:0] idx;
    } key_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [3:0] row_bits;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] column_drive;
    logic       key_valid;
    logic [6:0] key_char;
    logic [3:0] key_index;

    key_result_t pending_results[$];

    // scanner model state
    logic [HIST_W-1:0] key_hist [16];
    logic [1:0]        model_column;
    slot_t             key_ring [QUEUE_DEPTH];
    logic              ring_wr;
    logic              ring_rd;

    int err_count;
    int idle_max;
    int quiet_cycles;

    keypad_scan_debounce #(
        .HISTORY_BITS (HIST_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .row_bits     (row_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_drive (column_drive),
        .key_valid    (key_valid),
        .key_char     (key_char),
        .key_index    (key_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic key_result_t predict_keypad(input op_t op, input logic [3:0] rows);
        key_result_t       res;
        logic [3:0]        k;
        logic [HIST_W-1:0] h;
        slot_t             s;
        res = '0;
        if (op == OP_SCAN)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                k = {model_column, r[1:0]};
                h = {key_hist[k][HIST_W-2:0], rows[r]};
                key_hist[k] = h;
                // seven quiet samples then a high one: a fresh press
                if (h == HIST_W'(1))
                begin
                    key_ring[ring_wr].valid = 1'b1;
                    key_ring[ring_wr].idx   = k;
                    ring_wr = ~ring_wr;
                end
            end
            model_column = model_column + 2'd1;
        end
        else
        begin
            s = key_ring[ring_rd];
            if (s.valid)
            begin
                res.valid = 1'b1;
                res.idx   = s.idx;
                res.ch    = KEYMAP[(15 - int'(s.idx)) * 8 +: 7];
                key_ring[ring_rd] = '0;
                ring_rd = ~ring_rd;
            end
        end
        res.column = model_column;
        return res;
    endfunction

    task automatic send_item(input op_t op, input logic [3:0] rows);
        int gap;
        gap = $urandom_range(idle_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        row_bits <= rows;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_keypad(op, rows));
    endtask

    // result side: random stall before each beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = $urandom_range(idle_max, 0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        key_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: column %0d key_valid %0d",
                       column_drive, key_valid);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (column_drive !== want.column)
                begin
                    $error("column_drive: expected %0d, got %0d", want.column, column_drive);
                    err_count++;
                end
                if (key_valid !== want.valid)
                begin
                    $error("key_valid: expected %0d, got %0d", want.valid, key_valid);
                    err_count++;
                end
                if (key_char !== want.ch)
                begin
                    $error("key_char: expected 0x%02h, got 0x%02h", want.ch, key_char);
                    err_count++;
                end
                if (key_index !== want.idx)
                begin
                    $error("key_index: expected %0d, got %0d", want.idx, key_index);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_empty_pop();
        send_item(OP_POP, 4'hF);
        send_item(OP_POP, 4'h0);
    endtask

    // all four keys of column 0 press at once; the ring keeps the last two
    task automatic test_press_overflow();
        send_item(OP_SCAN, 4'hF);
        send_item(OP_POP, 4'h0);
        send_item(OP_POP, 4'hA);
        send_item(OP_POP, 4'h5);
    endtask

    task automatic test_last_key();
        send_item(OP_SCAN, 4'h0);
        send_item(OP_SCAN, 4'h0);
        send_item(OP_SCAN, 4'h8);
        send_item(OP_POP, 4'h0);
    endtask

    // second sweep with every key held must not press again
    task automatic test_held_keys();
        repeat (2)
        begin
            for (int c = 0; c < NUM_COLS; c++)
                send_item(OP_SCAN, 4'hF);
        end
        repeat (3) send_item(OP_POP, 4'h0);
    endtask

    task automatic test_random_traffic();
        int         pop_pct;
        int         sel;
        logic [3:0] rows;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % CHUNK_ITEMS == 0)
            begin
                pop_pct  = $urandom_range(60, 10);
                idle_max = ((n / CHUNK_ITEMS) % 4 == 3) ? 0 : 4;
            end
            rows = 4'($urandom());
            if ($urandom_range(99, 0) < pop_pct)
                send_item(OP_POP, rows);
            else
            begin
                sel = $urandom_range(99, 0);
                if (sel < 80)
                begin
                    // sparse contacts give quiet histories and fresh presses
                    for (int r = 0; r < NUM_ROWS; r++)
                        rows[r] = ($urandom_range(7, 0) == 0);
                end
                else if (sel < 90)
                    rows = 4'hF;
                send_item(OP_SCAN, rows);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_SCAN;
        row_bits     = 4'h0;
        idle_max     = 4;
        err_count    = 0;
        quiet_cycles = 0;
        for (int k = 0; k < 16; k++)
            key_hist[k] = '0;
        model_column = 2'd0;
        key_ring[0]  = '0;
        key_ring[1]  = '0;
        ring_wr      = 1'b0;
        ring_rd      = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_pop();
        test_press_overflow();
        test_last_key();
        test_held_keys();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
